>>> rtl/tdpf_pkg.sv
// ----------------------------------------------------------------------------
// tdpf_pkg
// Shared types for the tolerant duplicate point filter: point and result
// payloads, and the sequencer state codes.
// ----------------------------------------------------------------------------
package tdpf_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned TOL_W   = 31;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [TOL_W-1:0]   tol_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        logic   set_end;
    } in_item_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
        logic   keep;
        logic   set_done;
        logic   table_overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_STORE = 3'b100
    } state_t;

endpackage

>>> rtl/tolerant_duplicate_point_filter.sv
// ----------------------------------------------------------------------------
// tolerant_duplicate_point_filter
// Marks each point of a set as kept unless an earlier stored point of the
// same set lies strictly within the tolerance in x and y. Stored points are
// scanned one per cycle through a single compare unit.
// A point is taken only while idle; no new point is accepted until the scan
// of all stored points ends and its result is registered, which also waits
// while an earlier result is still held because m_ready is low.
// The table holds MAX_POINTS entries; once full, further points are not stored.
// Reset clears the point count and the tolerance returns to 66; the table
// contents are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
module tolerant_duplicate_point_filter
    import tdpf_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  tol_t      cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    logic [2*COORD_W-1:0] mem [MAX_POINTS];

    state_t           state_reg, state_next;
    tol_t             tol_reg;
    in_item_t         item_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             match_reg, match_next;
    logic [2*COORD_W-1:0] rd_data_reg;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg;

    logic rd_en;
    logic hit;
    logic store_go;
    logic full;
    logic in_xfer;

    tdpf_match u_match (
        .cur_x     (item_reg.point_x),
        .cur_y     (item_reg.point_y),
        .ref_x     (rd_data_reg[2*COORD_W-1:COORD_W]),
        .ref_y     (rd_data_reg[COORD_W-1:0]),
        .tolerance (tol_reg),
        .hit       (hit)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign full     = (count_reg == CNT_MAX);
    assign store_go = (state_reg == ST_STORE) && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_vld_next   = 1'b0;
        match_next     = match_reg;
        out_valid_next = out_valid_reg;
        rd_en          = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    rd_idx_next = '0;
                    match_next  = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmp_vld_reg && hit) begin
                    match_next = 1'b1;
                end
                if (rd_idx_reg < count_reg) begin
                    rd_en        = 1'b1;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end else if (!cmp_vld_reg) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (store_go) begin
                    out_valid_next = 1'b1;
                    if (item_reg.set_end) begin
                        count_next = '0;
                    end else if (!full) begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tol_reg       <= TOL_W'(66);
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            match_reg     <= match_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            item_reg <= s_data;
        end
        if (store_go) begin
            out_reg.out_x          <= item_reg.point_x;
            out_reg.out_y          <= item_reg.point_y;
            out_reg.out_z          <= item_reg.point_z;
            out_reg.keep           <= !match_reg;
            out_reg.set_done       <= item_reg.set_end;
            out_reg.table_overflow <= full;
        end
    end

    // table: registered read during the scan, write on store when not full
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
        if (store_go && !full) begin
            mem[count_reg[IDX_W-1:0]] <= {item_reg.point_x, item_reg.point_y};
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("point count exceeds table depth");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (rd_idx_reg <= count_reg))
        else $error("scan index beyond stored points");

    a_set_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (store_go && item_reg.set_end) |=> (count_reg == '0))
        else $error("table not cleared after final point of set");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == ST_SCAN && !s_ready))
        else $error("sequencer did not start scan after input transfer");

endmodule

>>> rtl/tdpf_match.sv
// ----------------------------------------------------------------------------
// tdpf_match
// Shared proximity compare: flags a stored point whose x and y both lie
// strictly within the tolerance of the current point.
// ----------------------------------------------------------------------------
module tdpf_match
    import tdpf_pkg::*;
(
    input  coord_t cur_x,
    input  coord_t cur_y,
    input  coord_t ref_x,
    input  coord_t ref_y,
    input  tol_t   tolerance,
    output logic   hit
);

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic        [COORD_W:0] adx;
    logic        [COORD_W:0] ady;

    always_comb begin
        dx  = {cur_x[COORD_W-1], cur_x} - {ref_x[COORD_W-1], ref_x};
        dy  = {cur_y[COORD_W-1], cur_y} - {ref_y[COORD_W-1], ref_y};
        adx = dx[COORD_W] ? -dx : dx;
        ady = dy[COORD_W] ? -dy : dy;
        hit = (adx < {2'b00, tolerance}) && (ady < {2'b00, tolerance});
    end

endmodule
